// File: src/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// shared types, codes and compare function for the priority command list
// ----------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int DATA_W  = 32;
    localparam int TDATA_W = ID_W + PRIO_W + DATA_W;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int OUSER_W = STAT_W + 1;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SORT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_EXECUTE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_SORT_KEY_RD,
        ST_SORT_KEY_LD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_REV_RD_A,
        ST_REV_RD_B,
        ST_REV_WR_A,
        ST_REV_WR_B,
        ST_LIST_RD,
        ST_LIST_OUT,
        ST_RESP
    } state_t;

    // higher priority first, then lower signed data
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic r;
        if (a.prio != b.prio)
        begin
            r = (a.prio > b.prio);
        end
        else
        begin
            r = ($signed(a.data) < $signed(b.data));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/priority_command_list.sv
// ----------------------------------------------------------------------------
// priority_command_list
// ordered list of up to DEPTH commands with insert, delete, modify, stable
// sort, reverse, read and execute, held in a simple dual-port memory
// ----------------------------------------------------------------------------
// One request is taken at a time; s_tready is low until its last result is
// in the output register. All list work goes through one memory read port,
// one write port and one comparator, so the time per request follows the
// number of memory accesses: insert needs no scan, delete and modify take
// longer with each entry scanned, delete also with each entry shifted,
// reverse with each swapped pair, read and execute with each entry listed
// (and longer still if m_tready stalls), and sort with each entry, each
// comparison and each entry that moves to the head.
`default_nettype none

module priority_command_list #(
    parameter int DEPTH = pcl_pkg::DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // target_id [15:0], cmd_priority [23:16], cmd_data [55:24]
    input  wire logic [pcl_pkg::TDATA_W-1:0] s_tdata,
    // req_type [2:0]
    input  wire logic [pcl_pkg::REQ_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // out_id [15:0], out_priority [23:16], out_data [55:24]
    output logic [pcl_pkg::TDATA_W-1:0]      m_tdata,
    // status [1:0], entry_valid [2]
    output logic [pcl_pkg::OUSER_W-1:0]      m_tuser,
    output logic                             m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;

    localparam int ID_W   = pcl_pkg::ID_W;
    localparam int PRIO_W = pcl_pkg::PRIO_W;
    localparam int DATA_W = pcl_pkg::DATA_W;

    pcl_pkg::state_t state_reg, state_next;

    logic [pcl_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [ID_W-1:0]            tid_reg, tid_next;
    logic [DATA_W-1:0]          cdata_reg, cdata_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [ID_W-1:0]            next_id_reg, next_id_next;
    logic [AW-1:0]              i_reg, i_next;
    logic [AW-1:0]              j_reg, j_next;
    pcl_pkg::entry_t            key_reg, key_next;
    pcl_pkg::entry_t            hold_reg, hold_next;
    logic [pcl_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]            res_id_reg, res_id_next;

    logic                       m_valid_reg, m_valid_next;
    logic [pcl_pkg::STAT_W-1:0] o_status_reg, o_status_next;
    logic                       o_evalid_reg, o_evalid_next;
    logic [ID_W-1:0]            o_id_reg, o_id_next;
    logic [PRIO_W-1:0]          o_prio_reg, o_prio_next;
    logic [DATA_W-1:0]          o_data_reg, o_data_next;
    logic                       o_last_reg, o_last_next;

    pcl_pkg::entry_t mem [DEPTH];
    pcl_pkg::entry_t rd_data_reg;
    pcl_pkg::entry_t wr_data;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;

    logic            s_accept;
    logic            out_free;
    logic            out_load;
    logic            list_full;
    logic            id_hit;
    logic            key_first;
    logic [XW-1:0]   i_inc1;
    logic [XW-1:0]   i_inc2;
    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   j_x;

    assign s_tready  = (state_reg == pcl_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign list_full = (count_reg == CW'(DEPTH));
    assign id_hit    = (rd_data_reg.id == tid_reg);
    assign key_first = pcl_pkg::goes_before(key_reg, rd_data_reg);
    assign i_inc1    = XW'(i_reg) + XW'(1);
    assign i_inc2    = XW'(i_reg) + XW'(2);
    assign cnt_x     = XW'(count_reg);
    assign j_x       = XW'(j_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcl_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        pcl_pkg::REQ_DELETE,
                        pcl_pkg::REQ_MODIFY:
                        begin
                            state_next = (count_reg == '0) ? pcl_pkg::ST_RESP
                                                           : pcl_pkg::ST_FIND_RD;
                        end
                        pcl_pkg::REQ_SORT:
                        begin
                            state_next = (count_reg < CW'(2)) ? pcl_pkg::ST_RESP
                                                              : pcl_pkg::ST_SORT_KEY_RD;
                        end
                        pcl_pkg::REQ_REVERSE:
                        begin
                            state_next = (count_reg < CW'(2)) ? pcl_pkg::ST_RESP
                                                              : pcl_pkg::ST_REV_RD_A;
                        end
                        pcl_pkg::REQ_EXECUTE,
                        pcl_pkg::REQ_READ:
                        begin
                            state_next = (count_reg == '0) ? pcl_pkg::ST_RESP
                                                           : pcl_pkg::ST_LIST_RD;
                        end
                        default:
                        begin
                            state_next = pcl_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            pcl_pkg::ST_FIND_RD:
            begin
                state_next = pcl_pkg::ST_FIND_CHK;
            end
            pcl_pkg::ST_FIND_CHK:
            begin
                if (id_hit)
                begin
                    if (req_reg == pcl_pkg::REQ_DELETE && i_inc1 < cnt_x)
                    begin
                        state_next = pcl_pkg::ST_DEL_RD;
                    end
                    else
                    begin
                        state_next = pcl_pkg::ST_RESP;
                    end
                end
                else
                begin
                    state_next = (i_inc1 == cnt_x) ? pcl_pkg::ST_RESP
                                                   : pcl_pkg::ST_FIND_RD;
                end
            end
            pcl_pkg::ST_DEL_RD:
            begin
                state_next = pcl_pkg::ST_DEL_WR;
            end
            pcl_pkg::ST_DEL_WR:
            begin
                state_next = (i_inc2 < cnt_x) ? pcl_pkg::ST_DEL_RD : pcl_pkg::ST_RESP;
            end
            pcl_pkg::ST_SORT_KEY_RD:
            begin
                state_next = pcl_pkg::ST_SORT_KEY_LD;
            end
            pcl_pkg::ST_SORT_KEY_LD:
            begin
                state_next = pcl_pkg::ST_SORT_CMP;
            end
            pcl_pkg::ST_SORT_CMP:
            begin
                if (key_first)
                begin
                    if (j_reg == AW'(1))
                    begin
                        state_next = pcl_pkg::ST_SORT_PUT;
                    end
                end
                else
                begin
                    state_next = (i_inc1 < cnt_x) ? pcl_pkg::ST_SORT_KEY_RD
                                                  : pcl_pkg::ST_RESP;
                end
            end
            pcl_pkg::ST_SORT_PUT:
            begin
                state_next = (i_inc1 < cnt_x) ? pcl_pkg::ST_SORT_KEY_RD : pcl_pkg::ST_RESP;
            end
            pcl_pkg::ST_REV_RD_A:
            begin
                state_next = pcl_pkg::ST_REV_RD_B;
            end
            pcl_pkg::ST_REV_RD_B:
            begin
                state_next = pcl_pkg::ST_REV_WR_A;
            end
            pcl_pkg::ST_REV_WR_A:
            begin
                state_next = pcl_pkg::ST_REV_WR_B;
            end
            pcl_pkg::ST_REV_WR_B:
            begin
                state_next = (i_inc2 < j_x) ? pcl_pkg::ST_REV_RD_A : pcl_pkg::ST_RESP;
            end
            pcl_pkg::ST_LIST_RD:
            begin
                state_next = pcl_pkg::ST_LIST_OUT;
            end
            pcl_pkg::ST_LIST_OUT:
            begin
                if (out_free)
                begin
                    state_next = (i_inc1 == cnt_x) ? pcl_pkg::ST_IDLE
                                                   : pcl_pkg::ST_LIST_RD;
                end
            end
            pcl_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = pcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcl_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next        = req_reg;
        tid_next        = tid_reg;
        cdata_next      = cdata_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        hold_next       = hold_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        rd_addr         = i_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg;
        wr_data         = rd_data_reg;
        out_load        = 1'b0;
        o_status_next   = pcl_pkg::STAT_OK;
        o_evalid_next   = 1'b0;
        o_id_next       = '0;
        o_prio_next     = '0;
        o_data_next     = '0;
        o_last_next     = 1'b1;

        case (state_reg)
            pcl_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    req_next        = s_tuser;
                    tid_next        = s_tdata[ID_W-1:0];
                    cdata_next      = s_tdata[pcl_pkg::TDATA_W-1:ID_W+PRIO_W];
                    i_next          = '0;
                    res_status_next = pcl_pkg::STAT_OK;
                    res_id_next     = '0;
                    case (s_tuser)
                        pcl_pkg::REQ_INSERT:
                        begin
                            if (list_full)
                            begin
                                res_status_next = pcl_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = count_reg[AW-1:0];
                                wr_data.id   = next_id_reg;
                                wr_data.prio = s_tdata[ID_W+PRIO_W-1:ID_W];
                                wr_data.data = s_tdata[pcl_pkg::TDATA_W-1:ID_W+PRIO_W];
                                res_id_next  = next_id_reg;
                                count_next   = count_reg + CW'(1);
                                next_id_next = next_id_reg + ID_W'(1);
                            end
                        end
                        pcl_pkg::REQ_DELETE,
                        pcl_pkg::REQ_MODIFY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = pcl_pkg::STAT_NOTFOUND;
                            end
                        end
                        pcl_pkg::REQ_SORT:
                        begin
                            i_next = AW'(1);
                        end
                        pcl_pkg::REQ_REVERSE:
                        begin
                            j_next = AW'(count_reg - CW'(1));
                        end
                        default:
                        begin
                            i_next = '0;
                        end
                    endcase
                end
            end
            pcl_pkg::ST_FIND_CHK:
            begin
                if (id_hit)
                begin
                    if (req_reg == pcl_pkg::REQ_MODIFY)
                    begin
                        wr_en        = 1'b1;
                        wr_data.data = cdata_reg;
                    end
                    else if (!(i_inc1 < cnt_x))
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    i_next = AW'(i_inc1);
                    if (i_inc1 == cnt_x)
                    begin
                        res_status_next = pcl_pkg::STAT_NOTFOUND;
                    end
                end
            end
            pcl_pkg::ST_DEL_RD:
            begin
                rd_addr = AW'(i_inc1);
            end
            pcl_pkg::ST_DEL_WR:
            begin
                wr_en  = 1'b1;
                i_next = AW'(i_inc1);
                if (!(i_inc2 < cnt_x))
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            pcl_pkg::ST_SORT_KEY_LD:
            begin
                key_next = rd_data_reg;
                j_next   = i_reg;
                rd_addr  = i_reg - AW'(1);
            end
            pcl_pkg::ST_SORT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (key_first)
                begin
                    j_next  = j_reg - AW'(1);
                    rd_addr = AW'(j_x - XW'(2));
                end
                else
                begin
                    wr_data = key_reg;
                    i_next  = AW'(i_inc1);
                end
            end
            pcl_pkg::ST_SORT_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = key_reg;
                i_next  = AW'(i_inc1);
            end
            pcl_pkg::ST_REV_RD_B:
            begin
                hold_next = rd_data_reg;
                rd_addr   = j_reg;
            end
            pcl_pkg::ST_REV_WR_A:
            begin
                wr_en = 1'b1;
            end
            pcl_pkg::ST_REV_WR_B:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = hold_reg;
                i_next  = AW'(i_inc1);
                j_next  = j_reg - AW'(1);
            end
            pcl_pkg::ST_LIST_OUT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_evalid_next = 1'b1;
                    o_id_next     = rd_data_reg.id;
                    o_prio_next   = rd_data_reg.prio;
                    o_data_next   = rd_data_reg.data;
                    o_last_next   = (i_inc1 == cnt_x);
                    if (i_inc1 == cnt_x)
                    begin
                        if (req_reg == pcl_pkg::REQ_EXECUTE)
                        begin
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        i_next = AW'(i_inc1);
                    end
                end
            end
            pcl_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_status_next = res_status_reg;
                    o_id_next     = res_id_reg;
                end
            end
            default:
            begin
                rd_addr = i_reg;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // list storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pcl_pkg::ST_IDLE;
            count_reg   <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        tid_reg        <= tid_next;
        cdata_reg      <= cdata_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        key_reg        <= key_next;
        hold_reg       <= hold_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            o_status_reg <= o_status_next;
            o_evalid_reg <= o_evalid_next;
            o_id_reg     <= o_id_next;
            o_prio_reg   <= o_prio_next;
            o_data_reg   <= o_data_next;
            o_last_reg   <= o_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_data_reg, o_prio_reg, o_id_reg};
    assign m_tuser  = {o_evalid_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

// File: src/pcl_checker.sv
// ----------------------------------------------------------------------------
// pcl_checker
// port-level checks for the priority command list
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [pcl_pkg::TDATA_W-1:0] m_tdata,
    input wire logic [pcl_pkg::OUSER_W-1:0] m_tuser,
    input wire logic                        m_tlast
);

    localparam int EV_BIT = pcl_pkg::STAT_W;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new request taken while busy");

    // a result without an entry always ends its request
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[EV_BIT] |-> m_tlast)
        else $error("non-entry result not last");

    // no entry means zero priority and data
    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[EV_BIT]
        |-> m_tdata[pcl_pkg::TDATA_W-1:pcl_pkg::ID_W] == '0)
        else $error("non-entry result carries payload");

    // listed entries always report ok
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[EV_BIT]
        |-> m_tuser[pcl_pkg::STAT_W-1:0] == pcl_pkg::STAT_OK)
        else $error("listed entry with error status");

endmodule

bind priority_command_list pcl_checker u_pcl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
